### design/sha1_pkg.sv
package sha1_pkg;

   localparam int WORDS  = 5;
   localparam int WINDOW = 16;
   localparam int ROUNDS = 80;

   localparam logic [31:0] CHAIN_INIT [WORDS] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K_CH   = 32'h5A827999;
   localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
   localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARKER = 8'h80;

   // byte positions inside a 64-byte block
   localparam logic [5:0] POS_LEN_FIRST   = 6'd56;
   localparam logic [5:0] POS_MARKER_LAST = 6'd55;
   localparam logic [5:0] POS_BLOCK_LAST  = 6'd63;

   localparam logic [6:0] ROUND_LAST    = 7'(ROUNDS - 1);
   localparam logic [6:0] ROUND_EXPAND  = 7'd16;
   localparam logic [6:0] ROUND_PAR1    = 7'd20;
   localparam logic [6:0] ROUND_MAJ     = 7'd40;
   localparam logic [6:0] ROUND_PAR2    = 7'd60;
   localparam logic [2:0] WORD_LAST     = 3'(WORDS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_PAD,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_MSG,
      SEL_MARKER,
      SEL_ZERO,
      SEL_LENGTH
   } byte_sel_type;

   typedef enum logic [1:0] {
      PH_CH,
      PH_PAR1,
      PH_MAJ,
      PH_PAR2
   } phase_type;

   typedef struct packed {
      logic         put_byte;
      byte_sel_type byte_sel;
      logic         count_bits;
      logic         latch_len;
      logic         load_vars;
      logic         round_step;
      logic         expand;
      phase_type    phase;
      logic         add_chain;
      logic         restart;
      logic [2:0]   word_sel;
   } cmd_type;

   typedef struct packed {
      logic [5:0] byte_pos;
   } status_type;

endpackage

### design/sha1_req_if.sv
interface sha1_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       byte_present;
   logic       end_of_message;

   modport source(output valid, output msg_byte, output byte_present,
                  output end_of_message, input ready);
   modport sink(input valid, input msg_byte, input byte_present,
                input end_of_message, output ready);
endinterface

### design/sha1_rsp_if.sv
interface sha1_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_number;
   logic        last_word;

   modport source(output valid, output digest_word, output word_number,
                  output last_word, input ready);
   modport sink(input valid, input digest_word, input word_number,
                input last_word, output ready);
endinterface

### design/sha1_ctrl.sv
module sha1_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_present,
   input  logic                req_end,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [2:0]          rsp_word_number,
   output logic                rsp_last_word,
   output sha1_pkg::cmd_type   cmd,
   input  sha1_pkg::status_type status
);
   import sha1_pkg::*;

   state_type  state_ff, state_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;
   logic       pad_ff, pad_in;        // end seen, padding in progress
   logic       marker_ff, marker_in;  // 0x80 already placed
   logic       lenph_ff, lenph_in;    // current block takes the length

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         round_ff  <= '0;
         word_ff   <= '0;
         pad_ff    <= 1'b0;
         marker_ff <= 1'b0;
         lenph_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
         pad_ff    <= pad_in;
         marker_ff <= marker_in;
         lenph_ff  <= lenph_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      round_in        = round_ff;
      word_in         = word_ff;
      pad_in          = pad_ff;
      marker_in       = marker_ff;
      lenph_in        = lenph_ff;
      cmd             = '0;
      cmd.byte_sel    = SEL_MSG;
      cmd.phase       = PH_CH;
      cmd.word_sel    = word_ff;
      req_ready       = 1'b0;
      rsp_valid       = 1'b0;
      rsp_word_number = word_ff;
      rsp_last_word   = (word_ff == WORD_LAST);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.put_byte   = req_present;
               cmd.count_bits = req_present;
               cmd.latch_len  = req_end;
               if (req_end) begin
                  pad_in    = 1'b1;
                  marker_in = 1'b0;
                  lenph_in  = 1'b0;
               end
               if (req_present && status.byte_pos == POS_BLOCK_LAST) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = ST_ROUND;
               end else if (req_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
            cmd.expand     = (round_ff >= ROUND_EXPAND);
            if (round_ff < ROUND_PAR1)
               cmd.phase = PH_CH;
            else if (round_ff < ROUND_MAJ)
               cmd.phase = PH_PAR1;
            else if (round_ff < ROUND_PAR2)
               cmd.phase = PH_MAJ;
            else
               cmd.phase = PH_PAR2;
            if (round_ff == ROUND_LAST)
               state_in = ST_ADD;
            else
               round_in = round_ff + 7'd1;
         end
         ST_ADD: begin
            cmd.add_chain = 1'b1;
            round_in      = '0;
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (lenph_ff) begin
               state_in = ST_OUT;
            end else begin
               // block without the length done; the next one carries it
               lenph_in = marker_ff;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            cmd.put_byte = 1'b1;
            if (!marker_ff) begin
               cmd.byte_sel = SEL_MARKER;
               marker_in    = 1'b1;
               lenph_in     = (status.byte_pos <= POS_MARKER_LAST);
            end else if (lenph_ff && status.byte_pos >= POS_LEN_FIRST) begin
               cmd.byte_sel = SEL_LENGTH;
            end else begin
               cmd.byte_sel = SEL_ZERO;
            end
            if (status.byte_pos == POS_BLOCK_LAST) begin
               cmd.load_vars = 1'b1;
               state_in      = ST_ROUND;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (word_ff == WORD_LAST) begin
                  cmd.restart = 1'b1;
                  word_in     = '0;
                  pad_in      = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while digest is being sent");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND |-> round_ff <= ROUND_LAST)
      else $error("round counter out of range");

   a_add_after_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADD |-> $past(state_ff) == ST_ROUND && $past(round_ff) == ROUND_LAST)
      else $error("chain add without a full set of rounds");

   a_out_final_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> pad_ff && lenph_ff && status.byte_pos == '0)
      else $error("digest sent before length block");

   a_idle_word: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> word_ff == '0)
      else $error("word counter not cleared");

endmodule

### design/sha1_dp.sv
module sha1_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           msg_byte,
   input  sha1_pkg::cmd_type    cmd,
   output sha1_pkg::status_type status,
   output logic [31:0]          digest_word
);
   import sha1_pkg::*;

   logic [31:0] window_ff [WINDOW];
   logic [23:0] acc_ff;
   logic [5:0]  pos_ff;
   logic [63:0] bit_count_ff, bit_count_in;
   logic [63:0] len_ff;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] chain_ff [WORDS];

   logic [7:0]  byte_val;
   logic [31:0] packed_word;
   logic [31:0] w_new, w_cur, f_val, k_val, t_val, shift_word;
   logic        shift_en;

   assign status.byte_pos = pos_ff;
   assign digest_word     = chain_ff[cmd.word_sel];

   always_comb begin
      case (cmd.byte_sel)
         SEL_MSG:    byte_val = msg_byte;
         SEL_MARKER: byte_val = PAD_MARKER;
         SEL_ZERO:   byte_val = 8'h00;
         SEL_LENGTH: byte_val = len_ff[{~pos_ff[2:0], 3'b000} +: 8];
         default:    byte_val = 8'h00;
      endcase
   end

   assign packed_word  = {acc_ff, byte_val};
   assign bit_count_in = cmd.count_bits ? bit_count_ff + 64'd8 : bit_count_ff;

   // schedule: window holds w[i-16..i-1] once expansion starts
   always_comb begin
      w_new = window_ff[13] ^ window_ff[8] ^ window_ff[2] ^ window_ff[0];
      w_new = {w_new[30:0], w_new[31]};
      w_cur = cmd.expand ? w_new : window_ff[0];
   end

   always_comb begin
      case (cmd.phase)
         PH_CH: begin
            f_val = (b_ff & c_ff) | (~b_ff & d_ff);
            k_val = K_CH;
         end
         PH_PAR1: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR1;
         end
         PH_MAJ: begin
            f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
            k_val = K_MAJ;
         end
         PH_PAR2: begin
            f_val = b_ff ^ c_ff ^ d_ff;
            k_val = K_PAR2;
         end
         default: begin
            f_val = '0;
            k_val = '0;
         end
      endcase
      t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;
   end

   assign shift_en   = cmd.round_step || (cmd.put_byte && pos_ff[1:0] == 2'b11);
   assign shift_word = cmd.round_step ? w_cur : packed_word;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         for (int j = 0; j < WINDOW - 1; j++)
            window_ff[j] <= window_ff[j+1];
         window_ff[WINDOW-1] <= shift_word;
      end
      if (cmd.put_byte)
         acc_ff <= packed_word[23:0];
      if (cmd.latch_len)
         len_ff <= bit_count_in;
      if (cmd.load_vars) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.round_step) begin
         a_ff <= t_val;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         bit_count_ff <= '0;
         for (int j = 0; j < WORDS; j++)
            chain_ff[j] <= CHAIN_INIT[j];
      end else begin
         if (cmd.put_byte)
            pos_ff <= pos_ff + 6'd1;
         if (cmd.restart) begin
            bit_count_ff <= '0;
            for (int j = 0; j < WORDS; j++)
               chain_ff[j] <= CHAIN_INIT[j];
         end else begin
            bit_count_ff <= bit_count_in;
            if (cmd.add_chain) begin
               chain_ff[0] <= chain_ff[0] + a_ff;
               chain_ff[1] <= chain_ff[1] + b_ff;
               chain_ff[2] <= chain_ff[2] + c_ff;
               chain_ff[3] <= chain_ff[3] + d_ff;
               chain_ff[4] <= chain_ff[4] + e_ff;
            end
         end
      end
   end

endmodule

### design/sha1_message_digest.sv
// channel  dir  handshake        payload
// req      in   valid / ready    msg_byte[7:0] byte_present end_of_message
// rsp      out  valid / ready    digest_word[31:0] word_number[2:0] last_word
//
// One byte beat per cycle while idle; the 64th byte of a block starts the round
// sequence and then the chain add. An end beat starts padding and a compression,
// twice over when the length spills into a new block; then five rsp beats, one
// per cycle while rsp.ready is high.
// Synchronous active-high reset restores the initial chain and clears counters.
// req.ready is low during compression, padding and digest output.
module sha1_message_digest (
   input  logic   clock,
   input  logic   reset,
   sha1_req_if.sink   req,
   sha1_rsp_if.source rsp
);
   import sha1_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: sequences byte packing, padding, rounds and output beats
   sha1_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req.valid),
      .req_present     (req.byte_present),
      .req_end         (req.end_of_message),
      .req_ready       (req.ready),
      .rsp_ready       (rsp.ready),
      .rsp_valid       (rsp.valid),
      .rsp_word_number (rsp.word_number),
      .rsp_last_word   (rsp.last_word),
      .cmd             (cmd),
      .status          (status)
   );

   // datapath: message window, round unit, chain value, length counter
   sha1_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .msg_byte    (req.msg_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp.digest_word)
   );

endmodule
